### hdl/tngd_pkg.sv
package tngd_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_MAC,
        ST_BIAS_RD,
        ST_BIAS_MAC,
        ST_MATH,
        ST_UPD,
        ST_RD_WAIT,
        ST_OUT
    } top_state_t;

    typedef enum logic [3:0] {
        M_IDLE,
        M_Z2,
        M_Z4,
        M_Z6,
        M_NUM,
        M_DEN,
        M_DIVI,
        M_DIV,
        M_Y,
        M_ERR,
        M_PROD,
        M_G,
        M_C,
        M_DONE
    } math_state_t;

    typedef struct packed {
        logic signed [15:0] y;
        logic [17:0]        loss;
        logic signed [46:0] c;
    } grad_res_t;

    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;

    localparam logic KIND_TRAIN = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic CFG_INIT_WEIGHT = 1'b0;
    localparam logic CFG_LEARN_RATE  = 1'b1;

    localparam logic signed [31:0] INIT_WEIGHT_RST = -32'sd167772;
    localparam logic [31:0]        LEARN_RATE_RST  = 32'd429497;

    localparam logic [18:0] Z_LIMIT = 19'd327680;
    localparam logic [39:0] TANH_K0 = 40'd8856207360;
    localparam logic [39:0] NUM_K2  = 40'd17325;
    localparam logic [39:0] NUM_K4  = 40'd378;
    localparam logic [39:0] DEN_K2  = 40'd62370;
    localparam logic [39:0] DEN_K4  = 40'd3150;
    localparam logic [39:0] DEN_K6  = 40'd28;

    localparam logic [15:0]        Y_MAX    = 16'd32767;
    localparam logic [17:0]        LOSS_MAX = 18'd262143;
    localparam logic signed [17:0] X_BIAS   = 18'sd65536;

endpackage

### hdl/tngd_ram.sv
module tngd_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/tngd_math.sv
module tngd_math
    import tngd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] acc,
    input  logic        is_tank,
    input  logic [31:0] learning_rate,
    output logic        done,
    output grad_res_t   res
);

    math_state_t state_reg, state_next;
    logic [4:0]  div_cnt_reg;

    logic               neg_reg;
    logic               tank_reg;
    logic [18:0]        z_reg;
    logic [20:0]        z2_reg;
    logic [25:0]        z4_reg;
    logic [30:0]        z6_reg;
    logic [39:0]        num_reg;
    logic [39:0]        den_reg;
    logic [59:0]        rem_reg;
    logic [57:0]        ds_reg;
    logic [17:0]        q_reg;
    logic signed [15:0] y_reg;
    logic signed [17:0] e_reg;
    logic signed [31:0] d_reg;
    logic signed [50:0] p_reg;
    logic [32:0]        ee_reg;
    logic signed [29:0] g_reg;
    logic signed [46:0] c_reg;
    logic [17:0]        loss_reg;

    logic [63:0]        mag;
    logic [39:0]        zraw;
    logic [37:0]        sq_z;
    logic [41:0]        sq_z2;
    logic [46:0]        pr_z6;
    logic [59:0]        ds_ext;
    logic [15:0]        q_lim;
    logic signed [17:0] target;
    logic signed [31:0] y_sq;
    logic signed [50:0] e_w;
    logic signed [50:0] d_w;
    logic signed [50:0] p_rnd;
    logic signed [35:0] e_sq;
    logic [33:0]        ee_rnd;
    logic signed [62:0] g_w;
    logic signed [62:0] lr_w;
    logic signed [62:0] gl_rnd;

    always_comb
    begin
        mag    = acc[63] ? (~acc + 64'd1) : acc;
        zraw   = mag[63:24];
        sq_z   = {19'd0, z_reg} * {19'd0, z_reg};
        sq_z2  = {21'd0, z2_reg} * {21'd0, z2_reg};
        pr_z6  = {21'd0, z4_reg} * {26'd0, z2_reg};
        ds_ext = {2'b00, ds_reg};
        q_lim  = (q_reg > {2'b00, Y_MAX}) ? Y_MAX : q_reg[15:0];
        target = tank_reg ? 18'sd32768 : -18'sd32768;
        y_sq   = 32'(y_reg) * 32'(y_reg);
        e_w    = 51'(e_reg);
        d_w    = 51'(d_reg);
        p_rnd  = p_reg + 51'sd1048576;
        e_sq   = 36'(e_reg) * 36'(e_reg);
        ee_rnd = {1'b0, ee_reg} + 34'd8192;
        g_w    = 63'(g_reg);
        lr_w   = $signed({31'd0, learning_rate});
        gl_rnd = g_w * lr_w + 63'sd32768;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE: if (start) state_next = M_Z2;
            M_Z2:   state_next = M_Z4;
            M_Z4:   state_next = M_Z6;
            M_Z6:   state_next = M_NUM;
            M_NUM:  state_next = M_DEN;
            M_DEN:  state_next = M_DIVI;
            M_DIVI: state_next = M_DIV;
            M_DIV:  if (div_cnt_reg == 5'd0) state_next = M_Y;
            M_Y:    state_next = M_ERR;
            M_ERR:  state_next = M_PROD;
            M_PROD: state_next = M_G;
            M_G:    state_next = M_C;
            M_C:    state_next = M_DONE;
            M_DONE: state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_comb
    begin
        done   = (state_reg == M_DONE);
        res.y    = y_reg;
        res.loss = loss_reg;
        res.c    = c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= M_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == M_DIVI)
            begin
                div_cnt_reg <= 5'd17;
            end
            else if (state_reg == M_DIV)
            begin
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    neg_reg  <= acc[63];
                    tank_reg <= is_tank;
                    z_reg    <= (zraw > {21'd0, Z_LIMIT}) ? Z_LIMIT : zraw[18:0];
                end
            end
            M_Z2:   z2_reg <= sq_z[36:16];
            M_Z4:   z4_reg <= sq_z2[41:16];
            M_Z6:   z6_reg <= pr_z6[46:16];
            M_NUM:
            begin
                num_reg <= TANH_K0 + NUM_K2 * 40'(z2_reg) + NUM_K4 * 40'(z4_reg)
                           + 40'(z6_reg);
            end
            M_DEN:
            begin
                den_reg <= TANH_K0 + DEN_K2 * 40'(z2_reg) + DEN_K4 * 40'(z4_reg)
                           + DEN_K6 * 40'(z6_reg);
            end
            M_DIVI:
            begin
                rem_reg <= 60'(num_reg) * 60'(z_reg) + 60'(den_reg);
                ds_reg  <= {den_reg, 18'd0};
                q_reg   <= '0;
            end
            M_DIV:
            begin
                if (rem_reg >= ds_ext)
                begin
                    rem_reg <= rem_reg - ds_ext;
                    q_reg   <= {q_reg[16:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[16:0], 1'b0};
                end
                ds_reg <= ds_reg >> 1;
            end
            M_Y:    y_reg <= neg_reg ? -$signed(q_lim) : $signed(q_lim);
            M_ERR:
            begin
                e_reg <= 18'(y_reg) - target;
                d_reg <= 32'sd1073741824 - y_sq;
            end
            M_PROD:
            begin
                p_reg  <= (e_w * d_w) <<< 1;
                ee_reg <= 33'(e_sq);
            end
            M_G:
            begin
                g_reg    <= p_rnd[50:21];
                loss_reg <= (ee_rnd[33:14] > {2'b00, LOSS_MAX}) ? LOSS_MAX : ee_rnd[31:14];
            end
            M_C:    c_reg <= gl_rnd[62:16];
            default: ;
        endcase
    end

endmodule

### hdl/tanh_neuron_gradient_descent_trainer_unit.sv
// Trains one tanh neuron on gray images, one pixel per input transaction (tuser 0); tuser 1
// reads one weight back and tuser 2 reloads every weight with initial_weight. A pixel without
// tlast is accepted and then multiply-accumulated with the weight read from the weight RAM. The
// pixel with tlast then reads and adds the bias, runs the tanh and gradient sequencer (with an
// 18-bit restoring division), and then an update pass over the N buffered pixels and the bias,
// one weight read-modify-write per cycle through the single write port of the weight RAM,
// before the result transaction is offered. After reset and after each reload command the
// block sweeps every entry of the weight RAM and accepts no input transaction meanwhile;
// configuration writes are taken at any time.
module tanh_neuron_gradient_descent_trainer_unit
    import tngd_pkg::*;
#(
    parameter int IMAGE_SIDE   = 64,
    parameter int WEIGHT_COUNT = 4097
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // pixel[15:0], is_tank[16], weight_index[29:17]
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // prediction[15:0], loss[33:16], weight_value[65:34]
    output logic        m_axis_tuser,  // kind[0]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int PIX_CAP = (IMAGE_SIDE * IMAGE_SIDE < WEIGHT_COUNT - 1) ?
                             IMAGE_SIDE * IMAGE_SIDE : WEIGHT_COUNT - 1;
    localparam int AW  = $clog2(WEIGHT_COUNT);
    localparam int BW  = $clog2(PIX_CAP);
    localparam int PCW = $clog2(PIX_CAP + 1);
    localparam logic [AW-1:0]  BIAS_ADDR = AW'(WEIGHT_COUNT - 1);
    localparam logic [PCW-1:0] CAP_CNT   = PCW'(PIX_CAP);

    top_state_t state_reg, state_next;

    logic [AW-1:0]      clr_cnt_reg;
    logic [31:0]        init_w_reg;
    logic [31:0]        lr_reg;
    logic [63:0]        acc_reg;
    logic [PCW-1:0]     pc_reg;
    logic [15:0]        pix_reg;
    logic               last_reg;
    logic               tank_reg;
    logic               rd_hit_reg;
    logic               pend_kind_reg;
    logic               upd_run_reg;
    logic [PCW-1:0]     upd_cnt_reg;
    logic               p1_valid_reg;
    logic               p1_bias_reg;
    logic [AW-1:0]      p1_addr_reg;
    logic               p2_valid_reg;
    logic [AW-1:0]      p2_addr_reg;
    logic signed [64:0] prod_reg;
    logic signed [31:0] p2_w_reg;
    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [15:0]        out_pred_reg;
    logic [17:0]        out_loss_reg;
    logic [31:0]        out_wv_reg;

    logic [1:0]  in_op;
    logic [15:0] in_pixel;
    logic        in_tank;
    logic [12:0] in_widx;
    logic        accept;
    logic        idx_ok;
    logic        pix_room;
    logic        out_free;
    logic        out_load;
    logic        upd_empty;

    logic          w_rd_en, w_wr_en, b_rd_en, b_wr_en;
    logic [AW-1:0] w_rd_addr, w_wr_addr;
    logic [31:0]   w_wr_data, w_rd_data;
    logic [BW-1:0] b_rd_addr, b_wr_addr;
    logic [15:0]   b_rd_data;

    logic               math_start, math_done;
    grad_res_t          math_res;
    logic [63:0]        acc_sum;
    logic signed [48:0] mac_prod;
    logic signed [17:0] upd_x;
    logic signed [64:0] upd_prod;
    logic signed [64:0] upd_rnd;
    logic signed [34:0] upd_new;
    logic [31:0]        upd_sat;

    assign in_op    = s_axis_tuser;
    assign in_pixel = s_axis_tdata[15:0];
    assign in_tank  = s_axis_tdata[16];
    assign in_widx  = s_axis_tdata[29:17];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign idx_ok        = 32'(in_widx) < 32'(WEIGHT_COUNT);
    assign pix_room      = pc_reg < CAP_CNT;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == ST_OUT) && out_free;
    assign upd_empty     = !upd_run_reg && !p1_valid_reg && !p2_valid_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {6'd0, out_wv_reg, out_loss_reg, out_pred_reg};

    always_comb
    begin
        mac_prod = $signed(w_rd_data) * $signed({1'b0, pix_reg});
        if (state_reg == ST_BIAS_MAC)
        begin
            acc_sum = acc_reg + {{16{w_rd_data[31]}}, w_rd_data, 16'd0};
        end
        else
        begin
            acc_sum = acc_reg + {{15{mac_prod[48]}}, mac_prod};
        end
        upd_x    = p1_bias_reg ? X_BIAS : $signed({2'b00, b_rd_data});
        upd_prod = 65'(math_res.c) * 65'(upd_x);
        upd_rnd  = prod_reg + 65'sd2147483648;
        upd_new  = 35'(p2_w_reg) - 35'($signed(upd_rnd[64:32]));
        if (upd_new > 35'sd2147483647)
        begin
            upd_sat = 32'h7FFF_FFFF;
        end
        else if (upd_new < -35'sd2147483648)
        begin
            upd_sat = 32'h8000_0000;
        end
        else
        begin
            upd_sat = upd_new[31:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == BIAS_ADDR) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_PIXEL:
                        begin
                            if (pix_room) state_next = ST_PIX_MAC;
                            else if (s_axis_tlast) state_next = ST_BIAS_RD;
                        end
                        OP_READ:  state_next = ST_RD_WAIT;
                        OP_RESET: state_next = ST_CLEAR;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIX_MAC:  state_next = last_reg ? ST_BIAS_RD : ST_IDLE;
            ST_BIAS_RD:  state_next = ST_BIAS_MAC;
            ST_BIAS_MAC: state_next = ST_MATH;
            ST_MATH:     if (math_done) state_next = ST_UPD;
            ST_UPD:      if (upd_empty) state_next = ST_OUT;
            ST_RD_WAIT:  state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        w_rd_en    = 1'b0;
        w_rd_addr  = '0;
        w_wr_en    = 1'b0;
        w_wr_addr  = clr_cnt_reg;
        w_wr_data  = init_w_reg;
        b_rd_en    = 1'b0;
        b_rd_addr  = upd_cnt_reg[BW-1:0];
        b_wr_en    = 1'b0;
        b_wr_addr  = pc_reg[BW-1:0];
        math_start = (state_reg == ST_BIAS_MAC);
        unique case (state_reg)
            ST_CLEAR: w_wr_en = 1'b1;
            ST_IDLE:
            begin
                if (accept && in_op == OP_PIXEL && pix_room)
                begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(pc_reg);
                    b_wr_en   = 1'b1;
                end
                else if (accept && in_op == OP_READ && idx_ok)
                begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(in_widx);
                end
            end
            ST_BIAS_RD:
            begin
                w_rd_en   = 1'b1;
                w_rd_addr = BIAS_ADDR;
            end
            ST_UPD:
            begin
                if (upd_run_reg)
                begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = (upd_cnt_reg == pc_reg) ? BIAS_ADDR : AW'(upd_cnt_reg);
                    b_rd_en   = (upd_cnt_reg != pc_reg);
                end
                w_wr_en   = p2_valid_reg;
                w_wr_addr = p2_addr_reg;
                w_wr_data = upd_sat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            init_w_reg    <= INIT_WEIGHT_RST;
            lr_reg        <= LEARN_RATE_RST;
            acc_reg       <= '0;
            pc_reg        <= '0;
            upd_run_reg   <= 1'b0;
            upd_cnt_reg   <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_INIT_WEIGHT: init_w_reg <= cfg_data;
                    CFG_LEARN_RATE:  lr_reg     <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (accept && in_op == OP_RESET)
            begin
                clr_cnt_reg <= '0;
                acc_reg     <= '0;
                pc_reg      <= '0;
            end
            if (state_reg == ST_PIX_MAC)
            begin
                acc_reg <= acc_sum;
                pc_reg  <= pc_reg + PCW'(1);
            end
            if (state_reg == ST_BIAS_MAC)
            begin
                acc_reg <= acc_sum;
            end
            if (state_reg == ST_MATH && math_done)
            begin
                upd_run_reg <= 1'b1;
                upd_cnt_reg <= '0;
            end
            p1_valid_reg <= (state_reg == ST_UPD) && upd_run_reg;
            p2_valid_reg <= p1_valid_reg;
            if (state_reg == ST_UPD && upd_run_reg)
            begin
                if (upd_cnt_reg == pc_reg)
                begin
                    upd_run_reg <= 1'b0;
                end
                else
                begin
                    upd_cnt_reg <= upd_cnt_reg + PCW'(1);
                end
            end
            if (state_reg == ST_UPD && upd_empty)
            begin
                acc_reg <= '0;
                pc_reg  <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg    <= in_pixel;
            last_reg   <= s_axis_tlast;
            rd_hit_reg <= idx_ok;
            if (in_op == OP_PIXEL)
            begin
                tank_reg <= in_tank;
            end
            pend_kind_reg <= (in_op == OP_READ) ? KIND_READ : KIND_TRAIN;
        end
        p1_bias_reg <= (upd_cnt_reg == pc_reg);
        p1_addr_reg <= w_rd_addr;
        p2_addr_reg <= p1_addr_reg;
        prod_reg    <= upd_prod;
        p2_w_reg    <= $signed(w_rd_data);
        if (out_load)
        begin
            out_kind_reg <= pend_kind_reg;
            if (pend_kind_reg == KIND_READ)
            begin
                out_pred_reg <= '0;
                out_loss_reg <= '0;
                out_wv_reg   <= rd_hit_reg ? w_rd_data : 32'd0;
            end
            else
            begin
                out_pred_reg <= math_res.y;
                out_loss_reg <= math_res.loss;
                out_wv_reg   <= '0;
            end
        end
    end

    tngd_ram #(
        .DEPTH (WEIGHT_COUNT),
        .WIDTH (32)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (w_wr_en),
        .wr_addr (w_wr_addr),
        .wr_data (w_wr_data),
        .rd_en   (w_rd_en),
        .rd_addr (w_rd_addr),
        .rd_data (w_rd_data)
    );

    tngd_ram #(
        .DEPTH (PIX_CAP),
        .WIDTH (16)
    ) u_image_ram (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (b_wr_addr),
        .wr_data (in_pixel),
        .rd_en   (b_rd_en),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    tngd_math u_math (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (math_start),
        .acc           (acc_sum),
        .is_tank       (tank_reg),
        .learning_rate (lr_reg),
        .done          (math_done),
        .res           (math_res)
    );

    // The image count never runs past the buffer capacity.
    a_pc_cap: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= CAP_CNT)
        else $error("pixel count beyond image capacity");

    // The gradient sequencer only finishes while the controller waits for it.
    a_math_done: assert property (@(posedge clk) disable iff (!rst_n)
        math_done |-> state_reg == ST_MATH)
        else $error("gradient sequencer finished outside its window");

    // A weight write-back never collides with a read of the same entry.
    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (w_wr_en && w_rd_en) |-> w_wr_addr != w_rd_addr)
        else $error("weight RAM read and write hit the same entry");

    // The update pipeline drains before the result transaction is formed.
    a_upd_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (!p1_valid_reg && !p2_valid_reg && !upd_run_reg))
        else $error("update pass still active at result");

endmodule
